// ===== design/icon_record_best_size_select_assert.svh =====
// Assertion helpers used by the icon record selector.
`ifndef ICON_RECORD_BEST_SIZE_SELECT_ASSERT_SVH
`define ICON_RECORD_BEST_SIZE_SELECT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IRBSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IRBSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/irbss_pkg.sv =====
`timescale 1ns / 1ps
package irbss_pkg;

  localparam int DIM_W  = 16;
  localparam int IDEAL_W = 17;
  localparam int CFG_IDX_W = 1;

  // result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_CAPACITY  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 1'd1;

  // one stored record header
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] offset;
  } hdr_t;

endpackage

// ===== design/icon_record_best_size_select.sv =====
// Icon record best-size selector. Takes a stream of 32-bit words (width, height, then
// width*height pixel words per record), one word per cycle on the in channel while parsing.
// Each record header is written to the header memory when its height word arrives. The
// word flagged last_word yields one result on the out channel. On a clean stream the block
// then walks the header memory, one entry per cycle, and holds in_stall high from the
// last word until the result appears; error streams report in the cycle after the
// last word. A last word is also held while an earlier result has not been transferred.
// There is no clearing pass after reset. Negative ideal sizes select the largest width
// or height present in the stream.
`timescale 1ns / 1ps
`include "icon_record_best_size_select_assert.svh"

module icon_record_best_size_select #(
  parameter int MAX_RECORDS      = 16,
  parameter int MAX_STREAM_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] word,
  input  logic        last_word,
  // result
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [irbss_pkg::DIM_W-1:0] best_width,
  output logic [irbss_pkg::DIM_W-1:0] best_height,
  output logic [irbss_pkg::DIM_W-1:0] best_offset,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [irbss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irbss_pkg::IDEAL_W-1:0]   cfg_data
);

  localparam int POS_W  = $clog2(MAX_STREAM_WORDS + 1);
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int DW     = irbss_pkg::DIM_W;

  localparam logic [1:0] PH_WIDTH  = 2'd0;
  localparam logic [1:0] PH_HEIGHT = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  // configuration
  logic [irbss_pkg::IDEAL_W-1:0] target_width;
  logic [irbss_pkg::IDEAL_W-1:0] target_height;

  // stream parse state
  logic [1:0]       parse_phase, parse_phase_next;
  logic [CNT_W-1:0] record_count, record_count_next;
  logic [POS_W-1:0] word_position, word_position_next;
  logic [31:0]      payload_left, payload_left_next;
  logic [DW-1:0]    max_width_seen, max_width_seen_next;
  logic [DW-1:0]    max_height_seen, max_height_seen_next;
  logic [1:0]       error_flag, error_flag_next;
  logic [DW-1:0]    cur_width, cur_width_next;

  // header memory
  irbss_pkg::hdr_t  hdr_mem [MAX_RECORDS];
  irbss_pkg::hdr_t  rd_data;
  irbss_pkg::hdr_t  wr_data;
  logic             mem_we;
  logic             mem_re;

  // selection walk
  logic             state, state_next;
  logic [CNT_W-1:0] issue_cnt;
  logic             rd_vld, rd_first, rd_last;
  logic [DW-1:0]    ideal;
  logic [DW-1:0]    best_w, best_h, best_off, best_avg;

  logic             accept;
  logic             walk_start;
  logic             walk_done;
  logic             emit;
  logic [1:0]       emit_status;
  logic             word_big;
  logic             count_full;
  logic [31:0]      prod;
  logic [31:0]      payload_dec;
  logic [POS_W:0]   pos_inc;
  logic [DW-1:0]    iw, ih;
  logic [DW:0]      ideal_sum;
  logic [DW-1:0]    cur_avg;
  logic [DW:0]      cur_sum;
  logic             take;
  irbss_pkg::hdr_t  chosen;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state == S_WALK) | (out_valid & last_word);
  assign accept    = in_valid & ~in_stall;

  assign word_big    = (word[31:DW] != '0);
  assign count_full  = (record_count >= CNT_W'(MAX_RECORDS));
  assign prod        = {16'd0, cur_width} * {16'd0, word[DW-1:0]};
  assign payload_dec = (payload_left != 32'd0) ? payload_left - 32'd1 : payload_left;
  assign pos_inc     = {1'b0, word_position} + (POS_W + 1)'(1);

  assign wr_data.width  = cur_width;
  assign wr_data.height = word[DW-1:0];
  assign wr_data.offset = DW'(pos_inc);

  // ideal average, taken with the maxima as they stand at the last word
  assign iw        = target_width[DW]  ? max_width_seen  : target_width[DW-1:0];
  assign ih        = target_height[DW] ? max_height_seen : target_height[DW-1:0];
  assign ideal_sum = {1'b0, iw} + {1'b0, ih};

  // candidate compare during the walk
  assign cur_sum = {1'b0, rd_data.width} + {1'b0, rd_data.height};
  assign cur_avg = cur_sum[DW:1];
  assign take    = rd_first
                 | ((best_avg < ideal) && (cur_avg >= ideal))
                 | ((best_avg < ideal) && (cur_avg > best_avg))
                 | ((best_avg > ideal) && (cur_avg >= ideal) && (cur_avg < best_avg));
  assign chosen  = take ? rd_data : {best_w, best_h, best_off};

  assign mem_re    = (state == S_WALK) && (issue_cnt < record_count);
  assign walk_done = (state == S_WALK) && rd_vld && rd_last;

  always_comb begin
    parse_phase_next     = parse_phase;
    record_count_next    = record_count;
    word_position_next   = word_position;
    payload_left_next    = payload_left;
    max_width_seen_next  = max_width_seen;
    max_height_seen_next = max_height_seen;
    error_flag_next      = error_flag;
    cur_width_next       = cur_width;
    state_next           = state;
    mem_we               = 1'b0;
    walk_start           = 1'b0;
    emit                 = 1'b0;
    emit_status          = irbss_pkg::ST_FOUND;

    if (accept) begin
      if (error_flag == irbss_pkg::ST_FOUND) begin
        if (word_position >= POS_W'(MAX_STREAM_WORDS)) begin
          error_flag_next = irbss_pkg::ST_CAPACITY;
        end else begin
          unique case (parse_phase)
            PH_WIDTH: begin
              if (count_full || word_big) begin
                error_flag_next = irbss_pkg::ST_CAPACITY;
              end else begin
                cur_width_next     = word[DW-1:0];
                parse_phase_next   = PH_HEIGHT;
                word_position_next = word_position + POS_W'(1);
              end
            end
            PH_HEIGHT: begin
              if (count_full || word_big) begin
                error_flag_next = irbss_pkg::ST_CAPACITY;
              end else begin
                mem_we = 1'b1;
                if (cur_width > max_width_seen) max_width_seen_next = cur_width;
                if (word[DW-1:0] > max_height_seen) max_height_seen_next = word[DW-1:0];
                payload_left_next  = prod;
                record_count_next  = record_count + CNT_W'(1);
                parse_phase_next   = (prod != 32'd0) ? PH_PIXELS : PH_WIDTH;
                word_position_next = word_position + POS_W'(1);
              end
            end
            PH_PIXELS: begin
              payload_left_next = payload_dec;
              if (payload_dec == 32'd0) parse_phase_next = PH_WIDTH;
              word_position_next = word_position + POS_W'(1);
            end
            default: begin
              parse_phase_next = PH_WIDTH;
            end
          endcase
        end
      end

      if (last_word) begin
        if (error_flag_next != irbss_pkg::ST_FOUND) begin
          emit        = 1'b1;
          emit_status = error_flag_next;
        end else if (parse_phase != PH_PIXELS || parse_phase_next == PH_PIXELS) begin
          emit        = 1'b1;
          emit_status = irbss_pkg::ST_MALFORMED;
        end else begin
          walk_start = 1'b1;
          state_next = S_WALK;
        end
      end
    end

    if (walk_done) begin
      emit       = 1'b1;
      state_next = S_IDLE;
    end

    // stream state goes back to its start once the result is settled
    if (emit) begin
      parse_phase_next     = PH_WIDTH;
      record_count_next    = '0;
      word_position_next   = '0;
      payload_left_next    = 32'd0;
      max_width_seen_next  = '0;
      max_height_seen_next = '0;
      error_flag_next      = irbss_pkg::ST_FOUND;
    end
  end

  // header memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[record_count[ADDR_W-1:0]] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= hdr_mem[issue_cnt[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_width    <= '1;
      target_height   <= '1;
      parse_phase     <= PH_WIDTH;
      record_count    <= '0;
      word_position   <= '0;
      payload_left    <= 32'd0;
      max_width_seen  <= '0;
      max_height_seen <= '0;
      error_flag      <= irbss_pkg::ST_FOUND;
      state           <= S_IDLE;
      issue_cnt       <= '0;
      rd_vld          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          irbss_pkg::CFG_TARGET_WIDTH:  target_width  <= cfg_data;
          irbss_pkg::CFG_TARGET_HEIGHT: target_height <= cfg_data;
          default: ;
        endcase
      end

      parse_phase     <= parse_phase_next;
      record_count    <= record_count_next;
      word_position   <= word_position_next;
      payload_left    <= payload_left_next;
      max_width_seen  <= max_width_seen_next;
      max_height_seen <= max_height_seen_next;
      error_flag      <= error_flag_next;
      state           <= state_next;

      if (walk_start) begin
        issue_cnt <= '0;
      end else if (mem_re) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      rd_vld <= mem_re;

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and walk bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    cur_width <= cur_width_next;
    if (walk_start) begin
      ideal <= ideal_sum[DW:1];
    end
    if (mem_re) begin
      rd_first <= (issue_cnt == '0);
      rd_last  <= (issue_cnt == record_count - CNT_W'(1));
    end
    if (rd_vld && (state == S_WALK)) begin
      best_w   <= chosen.width;
      best_h   <= chosen.height;
      best_off <= chosen.offset;
      best_avg <= take ? cur_avg : best_avg;
    end
    if (emit) begin
      status <= emit_status;
      if (walk_done) begin
        best_width  <= chosen.width;
        best_height <= chosen.height;
        best_offset <= chosen.offset;
      end else begin
        best_width  <= '0;
        best_height <= '0;
        best_offset <= '0;
      end
    end
  end

  `IRBSS_ASSERT_NOW(a_emit_slot_free, emit, !out_valid,
    "result produced while output register still full")
  `IRBSS_ASSERT_NOW(a_fail_fields_zero, out_valid && (status != irbss_pkg::ST_FOUND),
    (best_width == '0) && (best_height == '0) && (best_offset == '0),
    "failed result carries nonzero fields")
  `IRBSS_ASSERT_NOW(a_walk_bounds, state == S_WALK,
    (record_count != '0) && (issue_cnt <= record_count),
    "header walk outside stored records")
  `IRBSS_ASSERT_NEXT(a_error_sticky,
    (error_flag != irbss_pkg::ST_FOUND) && !(accept && last_word),
    error_flag == $past(error_flag), "error flag changed before stream end")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

localparam int unsigned MAX_HDRS  = 16;
localparam int unsigned MAX_WORDS = 65536;

typedef enum logic [1:0] {EXPECT_WIDTH, EXPECT_HEIGHT, IN_PIXELS} icon_parse_e;

typedef struct packed {
  logic [1:0]                  status;
  logic [irbss_pkg::DIM_W-1:0] width;
  logic [irbss_pkg::DIM_W-1:0] height;
  logic [irbss_pkg::DIM_W-1:0] offset;
} icon_pick_t;

typedef struct packed {
  logic [31:0] data;
  logic        last;
} stream_word_t;

class icon_pick_scoreboard;
  irbss_pkg::hdr_t               hdrs [MAX_HDRS];
  int unsigned                   nrec;
  int unsigned                   pos;
  int unsigned                   max_w;
  int unsigned                   max_h;
  logic [31:0]                   left;
  icon_parse_e                   phase;
  logic [1:0]                    flag;
  logic [irbss_pkg::IDEAL_W-1:0] ideal_w;
  logic [irbss_pkg::IDEAL_W-1:0] ideal_h;
  icon_pick_t                    expected_q [$];
  int unsigned                   checked;
  int unsigned                   errors;

  function new();
    ideal_w = '1;
    ideal_h = '1;
    checked = 0;
    errors = 0;
    clear_stream();
  endfunction

  function void clear_stream();
    nrec = 0;
    pos = 0;
    left = 0;
    phase = EXPECT_WIDTH;
    max_w = 0;
    max_h = 0;
    flag = irbss_pkg::ST_FOUND;
  endfunction

  function void set_ideal(logic [irbss_pkg::CFG_IDX_W-1:0] idx,
                          logic [irbss_pkg::IDEAL_W-1:0] val);
    if (idx == irbss_pkg::CFG_TARGET_WIDTH) ideal_w = val;
    else if (idx == irbss_pkg::CFG_TARGET_HEIGHT) ideal_h = val;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void take_word(logic [31:0] w);
    if (pos >= MAX_WORDS) begin
      flag = irbss_pkg::ST_CAPACITY;
      return;
    end
    case (phase)
      EXPECT_WIDTH: begin
        if (nrec >= MAX_HDRS || w > 32'hFFFF) begin
          flag = irbss_pkg::ST_CAPACITY;
          return;
        end
        hdrs[nrec].width = w[15:0];
        phase = EXPECT_HEIGHT;
      end
      EXPECT_HEIGHT: begin
        if (nrec >= MAX_HDRS || w > 32'hFFFF) begin
          flag = irbss_pkg::ST_CAPACITY;
          return;
        end
        hdrs[nrec].height = w[15:0];
        hdrs[nrec].offset = 16'(pos + 1);
        if (32'(hdrs[nrec].width) > max_w) max_w = 32'(hdrs[nrec].width);
        if (w > max_h) max_h = w;
        left = 32'(hdrs[nrec].width) * w;
        nrec++;
        phase = (left != 0) ? IN_PIXELS : EXPECT_WIDTH;
      end
      default: begin
        if (left > 0) left--;
        if (left == 0) phase = EXPECT_WIDTH;
      end
    endcase
    pos++;
  endfunction

  // one transfer on the input side; a result is predicted only on the last word
  function void note_input(logic [31:0] w, logic last);
    icon_parse_e phase_at_entry;
    icon_pick_t  r;
    int unsigned iw, ih, target, best_avg, cur_avg, i;
    phase_at_entry = phase;
    if (flag == irbss_pkg::ST_FOUND) take_word(w);
    if (!last) return;
    r = '0;
    r.status = irbss_pkg::ST_FOUND;
    if (flag != irbss_pkg::ST_FOUND) begin
      r.status = flag;
    end else if (phase_at_entry != IN_PIXELS || phase == IN_PIXELS || nrec == 0) begin
      r.status = irbss_pkg::ST_MALFORMED;
    end else begin
      iw = ideal_w[irbss_pkg::IDEAL_W-1] ? max_w : 32'(ideal_w[15:0]);
      ih = ideal_h[irbss_pkg::IDEAL_W-1] ? max_h : 32'(ideal_h[15:0]);
      target = (iw + ih) / 2;
      r.width = hdrs[0].width;
      r.height = hdrs[0].height;
      r.offset = hdrs[0].offset;
      for (i = 1; i < nrec; i++) begin
        best_avg = (32'(r.width) + 32'(r.height)) / 2;
        cur_avg = (32'(hdrs[i].width) + 32'(hdrs[i].height)) / 2;
        if ((best_avg < target && cur_avg >= target) ||
            (best_avg < target && cur_avg > best_avg) ||
            (best_avg > target && cur_avg >= target && cur_avg < best_avg)) begin
          r.width = hdrs[i].width;
          r.height = hdrs[i].height;
          r.offset = hdrs[i].offset;
        end
      end
    end
    expected_q.push_back(r);
    clear_stream();
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= 100) $display("tb_top: %s", msg);
  endtask

  task compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d", checked, name, got, want));
  endtask

  task check_result(input logic [1:0] st, input logic [15:0] bw, input logic [15:0] bh,
                    input logic [15:0] bo);
    icon_pick_t e;
    checked++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing pending (status %0d)",
                                checked, st));
      return;
    end
    e = expected_q.pop_front();
    compare_field("status", 16'(st), 16'(e.status));
    compare_field("best_width", bw, e.width);
    compare_field("best_height", bh, e.height);
    compare_field("best_offset", bo, e.offset);
  endtask
endclass

module tb_top;

  localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned PHASE_WORDS    = 95;
  localparam int unsigned HOLD_CYCLES    = 400;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [31:0]                     word = '0;
  logic                            last_word = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      status;
  logic [irbss_pkg::DIM_W-1:0]     best_width;
  logic [irbss_pkg::DIM_W-1:0]     best_height;
  logic [irbss_pkg::DIM_W-1:0]     best_offset;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [irbss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [irbss_pkg::IDEAL_W-1:0]   cfg_data = '0;

  icon_pick_scoreboard sb;
  stream_word_t        stim_q [$];
  int unsigned         sent = 0;
  int unsigned         streams = 0;
  int unsigned         results_seen = 0;
  int unsigned         settings = 1;

  icon_record_best_size_select DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .word       (word),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .best_width (best_width),
    .best_height(best_height),
    .best_offset(best_offset),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------- stream building ----------------

  function automatic void push_word(logic [31:0] w);
    stream_word_t it;
    it.data = w;
    it.last = 1'b0;
    stim_q.push_back(it);
  endfunction

  function automatic void mark_last();
    stim_q[stim_q.size()-1].last = 1'b1;
  endfunction

  // mostly tiny records; zero-pixel records may carry a full-range dimension
  function automatic void pick_dims(input bit need_pixels, output logic [31:0] w,
                                    output logic [31:0] h);
    int unsigned lo;
    lo = need_pixels ? 1 : 0;
    w = $urandom_range(4, lo);
    h = $urandom_range(4, lo);
    if (!need_pixels) begin
      case ($urandom_range(9))
        0: begin
          w = ($urandom_range(3) == 0) ? 32'd65535 : 32'($urandom_range(65535));
          h = 0;
        end
        1: begin
          h = ($urandom_range(3) == 0) ? 32'd65535 : 32'($urandom_range(65535));
          w = 0;
        end
        default: ;
      endcase
    end else if ($urandom_range(7) == 0) begin
      w = $urandom_range(12, 1);
      h = $urandom_range(2, 1);
    end
  endfunction

  // bad_hdr selects a header word (2*record + 0/1) to replace by an oversize value
  function automatic void add_stream(int unsigned nrec, int bad_hdr);
    logic [31:0] w, h, big;
    int unsigned i, n;
    for (i = 0; i < nrec; i++) begin
      pick_dims(i == nrec - 1, w, h);
      big = $urandom;
      if (big[31:16] == 0) big[16] = 1'b1;
      if ($urandom_range(3) == 0) big = 32'h0001_0000;
      push_word((bad_hdr == int'(2 * i)) ? big : w);
      push_word((bad_hdr == int'(2 * i + 1)) ? big : h);
      for (n = 0; n < w * h; n++) push_word($urandom);
    end
    mark_last();
  endfunction

  function automatic void add_random_stream();
    int unsigned pick, s, len, k, n, i;
    pick = $urandom_range(99);
    if (pick < 70) begin
      add_stream(($urandom_range(19) == 0) ? MAX_HDRS : $urandom_range(5, 1), -1);
    end else if (pick < 80) begin
      // cut short anywhere: may end on a header word or inside pixels
      s = stim_q.size();
      add_stream($urandom_range(4, 1), -1);
      len = stim_q.size() - s;
      k = $urandom_range(len - 2);
      while (stim_q.size() > s + k + 1) void'(stim_q.pop_back());
      mark_last();
    end else if (pick < 88) begin
      n = $urandom_range(4, 1);
      add_stream(n, $urandom_range(2 * n - 1));
    end else if (pick < 94) begin
      add_stream($urandom_range(MAX_HDRS + 2, MAX_HDRS + 1), -1);
    end else begin
      n = $urandom_range(6, 1);
      for (i = 0; i < n; i++) push_word($urandom_range(1) ? $urandom : $urandom_range(3));
      mark_last();
    end
  endfunction

  // ---------------- driving ----------------

  task automatic play_words();
    stream_word_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      if (!(sent >= 300 && sent < 500)) begin
        while ($urandom_range(99) < 33) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      word <= it.data;
      last_word <= it.last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_input(it.data, it.last);
      sent++;
      if (it.last) streams++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ideals(input logic [irbss_pkg::IDEAL_W-1:0] iw,
                            input logic [irbss_pkg::IDEAL_W-1:0] ih);
    cfg_valid <= 1'b1;
    cfg_index <= irbss_pkg::CFG_TARGET_WIDTH;
    cfg_data <= iw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_ideal(irbss_pkg::CFG_TARGET_WIDTH, iw);
    cfg_index <= irbss_pkg::CFG_TARGET_HEIGHT;
    cfg_data <= ih;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_ideal(irbss_pkg::CFG_TARGET_HEIGHT, ih);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // ---------------- result side ----------------

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(status, best_width, best_height, best_offset);
      results_seen++;
    end
  end

  // random stall, a quiet window, and one long hold so the input backs up
  initial begin : rx_pace
    bit held;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 30) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (results_seen >= 10 && results_seen < 20) ? 1'b0 :
                   ($urandom_range(99) < 33);
    end
  end

  initial begin : watchdog
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : main
    int ph;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed streams, ideal sizes at reset (use the largest present)
    push_word(1); push_word(1); push_word(32'hFFFF_FFFF); mark_last();
    // zero-pixel record ahead of a real one
    push_word(0); push_word(0); push_word(1); push_word(2); push_word(0);
    push_word(32'hFFFF_FFFF); mark_last();
    // ends on a width word, then on the height of an empty record
    push_word(5); mark_last();
    push_word(0); push_word(0); mark_last();
    // truncated in pixels
    push_word(2); push_word(2); push_word(32'h5555_5555); push_word(32'hAAAA_AAAA);
    mark_last();
    // oversize width, oversize height; trailing words are ignored
    push_word(32'h0001_0000); push_word(1); push_word(0); mark_last();
    push_word(1); push_word(32'hFFFF_FFFF); mark_last();
    // full-scale width in an empty record, then a small one
    push_word(65535); push_word(0); push_word(1); push_word(1); push_word(7); mark_last();
    play_words();
    drain();

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: ;
        1: set_ideals(17'd0, 17'd0);
        2: set_ideals(17'd65535, 17'd65535);
        3: set_ideals(17'h1FFFF, 17'd3);
        4: set_ideals(17'h10000, 17'd65535);
        5: set_ideals(17'd2, 17'h1FFFF);
        8: set_ideals(17'($urandom), 17'($urandom));
        default: set_ideals(17'($urandom_range(8)), 17'($urandom_range(8)));
      endcase
      while (stim_q.size() < PHASE_WORDS) add_random_stream();
      play_words();
      drain();
    end

    $display("tb_top: %0d words in %0d streams sent, %0d results checked", sent, streams,
             results_seen);
    $display("tb_top: %0d ideal size settings, incl. negative, zero and full scale",
             settings);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/irbss_pkg.sv
design/icon_record_best_size_select.sv
bench/tb_top.sv
